FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a named clock, disabled while reset is low.
`define LPE_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on the block clock and reset.
`define LPE_ASSERT(label, prop) \
  `LPE_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/lpe_pkg.sv
`default_nettype none

package lpe_pkg;

  // Field and datapath widths
  localparam int unsigned DEG_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OPA_W  = 64;
  localparam int unsigned OPB_W  = 32;
  localparam int unsigned PROD_W = OPB_W + OPB_W;
  localparam int unsigned ACC_W  = OPA_W + OPB_W;

  // Saturation limits of a 32-bit signed value
  localparam logic [DATA_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] LIM_NEG = 32'h8000_0000;

  // Request from the sequencer to the rounded multiplier
  typedef struct packed {
    logic start;
    logic neg;
  } mul_req_t;

  // Answer of the rounded multiplier
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } mul_rsp_t;

  // Magnitude of a 32-bit signed value (the most negative maps to 2^31)
  function automatic logic [OPB_W-1:0] mag32(logic [DATA_W-1:0] v);
    logic [OPB_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lpe_coef_rom.sv
`default_nettype none

module lpe_coef_rom #(
  parameter int unsigned MAX_DEGREE = 127,
  parameter int unsigned FRAC_BITS  = 30,
  localparam int unsigned IdxW      = $clog2(MAX_DEGREE + 1)
) (
  input  logic [IdxW-1:0]          idx_i,
  output logic [lpe_pkg::OPA_W-1:0] coef_a_o,
  output logic [lpe_pkg::OPA_W-1:0] coef_b_o
);
  import lpe_pkg::*;

  localparam logic [OPA_W-1:0] OneFx = 64'd1 << FRAC_BITS;

  logic [OPA_W-1:0] tab_a [MAX_DEGREE+1];
  logic [OPA_W-1:0] tab_b [MAX_DEGREE+1];

  // Build (2i-1)/i and (i-1)/i from 1/i rounded to nearest
  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_ent
    localparam logic [OPA_W-1:0] Div   = (g == 0) ? 64'd1 : 64'(g);
    localparam logic [OPA_W-1:0] Recip = (OneFx + Div / 2) / Div;
    assign tab_a[g] = (OneFx << 1) - Recip;
    assign tab_b[g] = OneFx - Recip;
  end

  // Look up the coefficients of the current step
  assign coef_a_o = tab_a[idx_i];
  assign coef_b_o = tab_b[idx_i];

endmodule

`default_nettype wire

FILE: rtl/core/lpe_rmul.sv
`default_nettype none

module lpe_rmul #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpe_pkg::mul_req_t         req_i,
  input  logic [lpe_pkg::OPA_W-1:0] opa_i,
  input  logic [lpe_pkg::OPB_W-1:0] opb_i,
  output lpe_pkg::mul_rsp_t         rsp_o
);
  import lpe_pkg::*;

  `include "assert_macros.svh"

  localparam logic [ACC_W-1:0] Half = 96'd1 << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    RM_IDLE = 5'b00001,
    RM_LO   = 5'b00010,
    RM_HI   = 5'b00100,
    RM_ACC  = 5'b01000,
    RM_RND  = 5'b10000
  } rm_state_e;

  rm_state_e         state_q, state_d;
  logic [OPA_W-1:0]  a_q, a_d;
  logic [OPB_W-1:0]  b_q, b_d;
  logic              neg_q, neg_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              done_q, done_d;

  logic [OPB_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]  q_full;
  logic              q_ovf;
  logic [DATA_W-1:0] lim;
  logic [DATA_W-1:0] mag;

  // Share one 32x32 multiplier between the low and high operand halves
  assign mul_a = (state_q == RM_HI) ? a_q[OPA_W-1:OPB_W] : a_q[OPB_W-1:0];
  assign mul_p = mul_a * b_q;

  // Drop the fraction bits, then saturate the magnitude
  assign q_full = acc_q >> FRAC_BITS;
  assign q_ovf  = |q_full[ACC_W-1:DATA_W];
  assign lim    = neg_q ? LIM_NEG : LIM_POS;
  assign mag    = (q_ovf || (q_full[DATA_W-1:0] > lim)) ? lim : q_full[DATA_W-1:0];

  // Sequence low product, high product, accumulate with rounding, finish
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      RM_IDLE: begin
        if (req_i.start) begin
          a_d     = opa_i;
          b_d     = opb_i;
          neg_d   = req_i.neg;
          state_d = RM_LO;
        end
      end
      RM_LO: begin
        prod_d  = mul_p;
        state_d = RM_HI;
      end
      RM_HI: begin
        acc_d   = {{(ACC_W-PROD_W){1'b0}}, prod_q};
        prod_d  = mul_p;
        state_d = RM_ACC;
      end
      RM_ACC: begin
        acc_d   = acc_q + {prod_q, {OPB_W{1'b0}}} + Half;
        state_d = RM_RND;
      end
      RM_RND: begin
        res_d   = neg_q ? (~mag + 32'd1) : mag;
        done_d  = 1'b1;
        state_d = RM_IDLE;
      end
      default: begin
        state_d = RM_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

  `LPE_ASSERT(a_start_when_idle, req_i.start |-> state_q == RM_IDLE)
  `LPE_ASSERT(a_done_after_round, rsp_o.done |-> $past(state_q == RM_RND))
  `LPE_ASSERT(a_pos_fits, rsp_o.done && !neg_q |-> !rsp_o.value[DATA_W-1])

endmodule

`default_nettype wire

FILE: rtl/core/legendre_polynomial_eval_unit.sv
`default_nettype none

// Evaluates the Legendre polynomial P_n(x) for a signed 8-bit degree n and a
// signed fixed-point argument x (FRAC_BITS fraction bits, Q2.30 by default)
// with the three-term recurrence P_i = A_i*x*P_(i-1) - B_i*P_(i-2), where
// A_i = (2i-1)/i and B_i = (i-1)/i come from a rounded constant table.
// Every product is rounded to nearest (ties away from zero) and saturated to
// 32 bits, as is each new P_i. A degree above MAX_DEGREE is clamped to it; a
// negative degree returns 0 with tuser (bad_degree) set; degree 0 returns 1.0.
// All products run on one shared 32x32 multiplier, three products per
// recurrence step; degree 0, 1 or a negative degree needs no product. The
// block takes one request at a time; a finished result waits in the output
// register while the next request is accepted.
module legendre_polynomial_eval_unit #(
  parameter int unsigned MAX_DEGREE = 127,
  parameter int unsigned FRAC_BITS  = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] degree, [39:8] arg_x
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] poly_value
  output logic        m_axis_tuser    // [0] bad_degree
);
  import lpe_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned DegW = $clog2(MAX_DEGREE + 1);
  localparam logic [DATA_W-1:0] OneSat =
    (FRAC_BITS >= 31) ? LIM_POS : 32'(64'd1 << FRAC_BITS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_XP   = 8'b0000_0010,
    S_XP_W = 8'b0000_0100,
    S_T1   = 8'b0000_1000,
    S_T1_W = 8'b0001_0000,
    S_T2   = 8'b0010_0000,
    S_T2_W = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } seq_state_e;

  seq_state_e        state_q, state_d;
  logic [DegW-1:0]   n_q, n_d;
  logic [DegW-1:0]   i_q, i_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] p_q, p_d;
  logic [DATA_W-1:0] pp_q, pp_d;
  logic [DATA_W-1:0] xp_q, xp_d;
  logic [DATA_W-1:0] t1_q, t1_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              flag_q, flag_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_flag_q, out_flag_d;

  logic              in_fire;
  logic              out_load;
  logic [DEG_W-1:0]  deg_in;
  logic [DEG_W-2:0]  deg_mag;
  logic [DEG_W-2:0]  deg_clamp;
  logic [DATA_W-1:0] arg_in;

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic [OPA_W-1:0]  mul_opa;
  logic [OPB_W-1:0]  mul_opb;
  logic [OPA_W-1:0]  coef_a;
  logic [OPA_W-1:0]  coef_b;

  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] new_p;

  lpe_coef_rom #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_coef_rom (
    .idx_i    (i_q),
    .coef_a_o (coef_a),
    .coef_b_o (coef_b)
  );

  lpe_rmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .opa_i  (mul_opa),
    .opb_i  (mul_opb),
    .rsp_o  (mul_rsp)
  );

  // Unpack the request
  assign deg_in    = s_axis_tdata[DEG_W-1:0];
  assign arg_in    = s_axis_tdata[DEG_W+DATA_W-1:DEG_W];
  assign deg_mag   = deg_in[DEG_W-2:0];
  assign deg_clamp = (deg_mag > 7'(MAX_DEGREE)) ? 7'(MAX_DEGREE) : deg_mag;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Pick the operands of the product issued in this state
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.neg   = 1'b0;
    mul_opa       = {{(OPA_W-OPB_W){1'b0}}, mag32(x_q)};
    mul_opb       = mag32(p_q);
    case (state_q)
      S_XP: begin
        mul_req.start = 1'b1;
        mul_req.neg   = x_q[DATA_W-1] ^ p_q[DATA_W-1];
      end
      S_T1: begin
        mul_req.start = 1'b1;
        mul_req.neg   = xp_q[DATA_W-1];
        mul_opa       = coef_a;
        mul_opb       = mag32(xp_q);
      end
      S_T2: begin
        mul_req.start = 1'b1;
        mul_req.neg   = pp_q[DATA_W-1];
        mul_opa       = coef_b;
        mul_opb       = mag32(pp_q);
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // Subtract the two terms and saturate the new P_i
  assign diff  = {t1_q[DATA_W-1], t1_q} - {mul_rsp.value[DATA_W-1], mul_rsp.value};
  assign new_p = (diff[DATA_W] != diff[DATA_W-1]) ?
                 (diff[DATA_W] ? LIM_NEG : LIM_POS) : diff[DATA_W-1:0];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Step through the recurrence
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    x_d     = x_q;
    p_d     = p_q;
    pp_d    = pp_q;
    xp_d    = xp_q;
    t1_d    = t1_q;
    res_d   = res_q;
    flag_d  = flag_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_d    = arg_in;
          n_d    = deg_clamp[DegW-1:0];
          i_d    = DegW'(2);
          pp_d   = OneSat;
          p_d    = arg_in;
          flag_d = 1'b0;
          if (deg_in[DEG_W-1]) begin
            res_d   = '0;
            flag_d  = 1'b1;
            state_d = S_DONE;
          end else if (deg_mag == 7'd0) begin
            res_d   = OneSat;
            state_d = S_DONE;
          end else if (deg_mag == 7'd1) begin
            res_d   = arg_in;
            state_d = S_DONE;
          end else begin
            state_d = S_XP;
          end
        end
      end
      S_XP: state_d = S_XP_W;
      S_XP_W: begin
        if (mul_rsp.done) begin
          xp_d    = mul_rsp.value;
          state_d = S_T1;
        end
      end
      S_T1: state_d = S_T1_W;
      S_T1_W: begin
        if (mul_rsp.done) begin
          t1_d    = mul_rsp.value;
          state_d = S_T2;
        end
      end
      S_T2: state_d = S_T2_W;
      S_T2_W: begin
        if (mul_rsp.done) begin
          pp_d = p_q;
          p_d  = new_p;
          if (i_q == n_q) begin
            res_d   = new_p;
            state_d = S_DONE;
          end else begin
            i_d     = i_q + DegW'(1);
            state_d = S_XP;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_flag_d  = out_flag_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
      out_flag_d  = flag_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    x_q        <= x_d;
    p_q        <= p_d;
    pp_q       <= pp_d;
    xp_q       <= xp_d;
    t1_q       <= t1_d;
    res_q      <= res_d;
    flag_q     <= flag_d;
    out_data_q <= out_data_d;
    out_flag_q <= out_flag_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flag_q;

  `LPE_ASSERT(a_bad_degree_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
  `LPE_ASSERT(a_step_in_range, state_q == S_XP |-> i_q >= DegW'(2) && i_q <= n_q)
  `LPE_ASSERT(a_done_while_waiting,
    mul_rsp.done |-> state_q == S_XP_W || state_q == S_T1_W || state_q == S_T2_W)

endmodule

`default_nettype wire
